>>> design/crc8_framed_datagram_receiver_top_defines.svh
// assertion macros for the crc8 framed datagram receiver
// no dependencies; taken in by the files that carry assertions

`ifndef CRC8_FRAMED_DATAGRAM_RECEIVER_TOP_DEFINES_SVH
`define CRC8_FRAMED_DATAGRAM_RECEIVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define CRC8FDR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("crc8fdr assertion failed");

`define CRC8FDR_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("crc8fdr forbidden condition seen");

`else

`define CRC8FDR_ASSERT(label, clk, rst_n, prop)

`define CRC8FDR_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> design/crc8fdr_pkg.sv
// shared constants for the crc8 framed datagram receiver
// no dependencies; imported by crc8_framed_datagram_receiver_top

package crc8fdr_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned PAYLOAD_W     = 32;
    localparam int unsigned PAYLOAD_BYTES = PAYLOAD_W / BYTE_W;

    localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT   = 8'h00;
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h05;
    localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h00;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_BYTE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS = 2'd1;

    localparam int unsigned FRAME_BYTES_DEF = 7;
    localparam int unsigned SYNC_POS_DEF    = 0;
    localparam int unsigned ADDR_POS_DEF    = 1;
    localparam int unsigned PAYLOAD_POS_DEF = 2;

endpackage

>>> design/crc8_framed_datagram_receiver_top.sv
// crc8 framed datagram receiver: byte window, bit-serial crc-8 check, result register
// depends on crc8fdr_pkg and crc8_framed_datagram_receiver_top_defines.svh
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------
//   input   | in_valid / in_ready  | rx_byte
//   output  | out_valid / out_ready| frame_found, payload_word
//   config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// each beat is checked by the single crc bit step, which walks every bit of the window
// but the last byte once
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register and a new beat may be taken meanwhile
// reset clears the window, found flag and registers to their defaults; cfg_ready is always high

`include "crc8_framed_datagram_receiver_top_defines.svh"

module crc8_framed_datagram_receiver_top #(
    parameter int unsigned FRAME_BYTES = crc8fdr_pkg::FRAME_BYTES_DEF,
    parameter int unsigned SYNC_POS    = crc8fdr_pkg::SYNC_POS_DEF,
    parameter int unsigned ADDR_POS    = crc8fdr_pkg::ADDR_POS_DEF,
    parameter int unsigned PAYLOAD_POS = crc8fdr_pkg::PAYLOAD_POS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [crc8fdr_pkg::BYTE_W-1:0]      rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                frame_found,
    output logic [crc8fdr_pkg::PAYLOAD_W-1:0]   payload_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crc8fdr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crc8fdr_pkg::BYTE_W-1:0]      cfg_data
);
    import crc8fdr_pkg::*;

    localparam int unsigned CRC_BITS = (FRAME_BYTES - 1) * BYTE_W;
    localparam int unsigned CNT_W    = $clog2(CRC_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [BYTE_W-1:0]       win_reg [FRAME_BYTES];
    logic [BYTE_W-1:0]       win_next [FRAME_BYTES];
    logic [CRC_BITS-1:0]     data_reg, data_next;
    logic [BYTE_W-1:0]       crc_reg, crc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    found_reg, found_next;
    logic [BYTE_W-1:0]       sync_reg, sync_next;
    logic [BYTE_W-1:0]       addr_reg, addr_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    frame_found_reg, frame_found_next;
    logic [PAYLOAD_W-1:0]    payload_reg, payload_next;

    logic                    in_beat;
    logic                    crc_last;
    logic                    frame_hit;
    logic [BYTE_W-1:0]       sync_val;
    logic [BYTE_W-1:0]       addr_val;
    logic [BYTE_W-1:0]       pay_byte [PAYLOAD_BYTES];
    logic [PAYLOAD_W-1:0]    pay_word;
    logic [BYTE_W-1:0]       crc_step;

    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign frame_found  = frame_found_reg;
    assign payload_word = payload_reg;

    assign in_beat  = in_valid && in_ready;
    assign crc_last = (cnt_reg == CNT_W'(CRC_BITS - 1));

    // fixed window taps; positions past the window read as zero
    if (SYNC_POS < FRAME_BYTES) begin : g_sync_in
        assign sync_val = win_reg[SYNC_POS];
    end else begin : g_sync_out
        assign sync_val = '0;
    end

    if (ADDR_POS < FRAME_BYTES) begin : g_addr_in
        assign addr_val = win_reg[ADDR_POS];
    end else begin : g_addr_out
        assign addr_val = '0;
    end

    for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_pay
        if (PAYLOAD_POS + k < FRAME_BYTES) begin : g_in
            assign pay_byte[k] = win_reg[PAYLOAD_POS + k];
        end else begin : g_out
            assign pay_byte[k] = '0;
        end
    end

    always_comb
    begin
        for (int k = 0; k < PAYLOAD_BYTES; k++)
        begin
            pay_word[(PAYLOAD_BYTES - 1 - k) * BYTE_W +: BYTE_W] = pay_byte[k];
        end
    end

    assign frame_hit = (sync_val == sync_reg) && (addr_val == addr_reg) &&
                       (crc_reg == win_reg[FRAME_BYTES - 1]);

    // shared crc unit: one bit per cycle, lsb first
    always_comb
    begin
        crc_step = {crc_reg[BYTE_W-2:0], 1'b0};
        if (crc_reg[BYTE_W-1] ^ data_reg[0])
        begin
            crc_step = crc_step ^ CRC_POLY;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        win_next         = win_reg;
        data_next        = data_reg;
        crc_next         = crc_reg;
        cnt_next         = cnt_reg;
        found_next       = found_reg;
        sync_next        = sync_reg;
        addr_next        = addr_reg;
        out_valid_next   = out_valid_reg;
        frame_found_next = frame_found_reg;
        payload_next     = payload_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SYNC_BYTE:     sync_next = cfg_data;
                CFG_SLAVE_ADDRESS: addr_next = cfg_data;
                default:           ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    // window clears on the beat after a found frame
                    for (int i = 0; i < FRAME_BYTES - 1; i++)
                    begin
                        win_next[i] = found_reg ? '0 : win_reg[i + 1];
                    end
                    win_next[FRAME_BYTES - 1] = rx_byte;
                    for (int i = 0; i < FRAME_BYTES - 1; i++)
                    begin
                        data_next[i * BYTE_W +: BYTE_W] = win_next[i];
                    end
                    found_next = 1'b0;
                    crc_next   = CRC_INIT;
                    cnt_next   = '0;
                    state_next = ST_CRC;
                end
            end
            ST_CRC:
            begin
                crc_next  = crc_step;
                data_next = data_reg >> 1;
                cnt_next  = cnt_reg + 1'b1;
                if (crc_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    found_next       = frame_hit;
                    out_valid_next   = 1'b1;
                    frame_found_next = frame_hit;
                    payload_next     = frame_hit ? pay_word : '0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                win_reg[i] <= '0;
            end
            found_reg       <= 1'b0;
            sync_reg        <= SYNC_RESET;
            addr_reg        <= ADDR_RESET;
            out_valid_reg   <= 1'b0;
            frame_found_reg <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            win_reg         <= win_next;
            found_reg       <= found_next;
            sync_reg        <= sync_next;
            addr_reg        <= addr_next;
            out_valid_reg   <= out_valid_next;
            frame_found_reg <= frame_found_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg    <= data_next;
        crc_reg     <= crc_next;
        payload_reg <= payload_next;
    end

    `CRC8FDR_ASSERT(a_clear_after_find, clk, rst_n, (in_beat && found_reg) |=> (win_reg[0] == '0))
    `CRC8FDR_ASSERT(a_crc_ends, clk, rst_n, (state_reg == ST_CRC && crc_last) |=> (state_reg == ST_DONE))
    `CRC8FDR_ASSERT_NEVER(a_payload_zero, clk, rst_n, out_valid_reg && !frame_found_reg && payload_reg != '0)

endmodule

>>> bench/tb_crc8_framed_datagram_receiver_top.sv
// self-checking bench for crc8_framed_datagram_receiver_top: drives received bytes and
// register writes, predicts the frame search over the byte window and compares every result
// depends on crc8fdr_pkg and the design files only

module tb_crc8_framed_datagram_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crc8fdr_pkg::*;

    localparam int unsigned WIN_LEN    = FRAME_BYTES_DEF;
    localparam int unsigned SYNC_AT    = SYNC_POS_DEF;
    localparam int unsigned ADDR_AT    = ADDR_POS_DEF;
    localparam int unsigned PAYLOAD_AT = PAYLOAD_POS_DEF;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef logic [BYTE_W-1:0] window_t [WIN_LEN];

    typedef struct packed {
        logic                 found;
        logic [PAYLOAD_W-1:0] word;
    } frame_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [BYTE_W-1:0]      rx_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   frame_found;
    logic [PAYLOAD_W-1:0]   payload_word;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data = '0;

    window_t           rx_window = '{default: '0};
    logic              hit_latched = 1'b0;
    logic [BYTE_W-1:0] sync_value = SYNC_RESET;
    logic [BYTE_W-1:0] addr_value = ADDR_RESET;

    frame_result_t pending_frames[$];
    int unsigned   errors = 0;
    int unsigned   rx_hold = 0;
    bit            tx_steady = 1'b0;
    bit            rx_steady = 1'b0;

    crc8_framed_datagram_receiver_top #(
        .FRAME_BYTES (WIN_LEN),
        .SYNC_POS    (SYNC_AT),
        .ADDR_POS    (ADDR_AT),
        .PAYLOAD_POS (PAYLOAD_AT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_found  (frame_found),
        .payload_word (payload_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #4ms;
        $display("[crc8_framed_datagram_receiver_top] ERROR");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // crc-8 over all but the last window byte, each byte lsb first
    function automatic logic [BYTE_W-1:0] window_crc(window_t w);
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] cur;
        crc = CRC_INIT;
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            cur = w[i];
            for (int b = 0; b < BYTE_W; b++)
            begin
                if (crc[BYTE_W-1] ^ cur[0])
                    crc = {crc[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
                else
                    crc = {crc[BYTE_W-2:0], 1'b0};
                cur = cur >> 1;
            end
        end
        return crc;
    endfunction

    function automatic logic [BYTE_W-1:0] window_byte(window_t w, int unsigned pos);
        return (pos < WIN_LEN) ? w[pos] : '0;
    endfunction

    function automatic frame_result_t predict_rx_byte(logic [BYTE_W-1:0] b);
        frame_result_t r;
        if (hit_latched)
        begin
            hit_latched = 1'b0;
            foreach (rx_window[i])
                rx_window[i] = '0;
        end
        for (int i = 0; i < WIN_LEN - 1; i++)
            rx_window[i] = rx_window[i+1];
        rx_window[WIN_LEN-1] = b;
        if (window_byte(rx_window, SYNC_AT) == sync_value &&
            window_byte(rx_window, ADDR_AT) == addr_value &&
            window_crc(rx_window) == rx_window[WIN_LEN-1])
            hit_latched = 1'b1;
        r.found = hit_latched;
        r.word = '0;
        if (hit_latched)
            r.word = {window_byte(rx_window, PAYLOAD_AT),
                      window_byte(rx_window, PAYLOAD_AT + 1),
                      window_byte(rx_window, PAYLOAD_AT + 2),
                      window_byte(rx_window, PAYLOAD_AT + 3)};
        return r;
    endfunction

    task automatic check_frame_result();
        frame_result_t want;
        if (pending_frames.size() == 0)
        begin
            $error("unexpected result beat: frame_found %0b payload_word %h",
                   frame_found, payload_word);
            errors++;
        end
        else
        begin
            want = pending_frames.pop_front();
            if (frame_found !== want.found)
            begin
                $error("frame_found: expected %0b, got %0b", want.found, frame_found);
                errors++;
            end
            if (payload_word !== want.word)
            begin
                $error("payload_word: expected %h, got %h", want.word, payload_word);
                errors++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_frame_result();
        if (rx_hold != 0)
        begin
            rx_hold <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rst_n && !rx_steady && $urandom_range(0, 7) == 0)
                rx_hold <= pick_gap();
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!in_ready);
        pending_frames.push_back(predict_rx_byte(b));
    endtask

    task automatic settle_results();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
    endtask

    // only called with no beat in flight
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_SYNC_BYTE:     sync_value = data;
            CFG_SLAVE_ADDRESS: addr_value = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] sync, input logic [BYTE_W-1:0] addr);
        settle_results();
        write_reg(CFG_SYNC_BYTE, sync);
        write_reg(CFG_SLAVE_ADDRESS, addr);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] sync, input logic [BYTE_W-1:0] addr,
                              input logic [PAYLOAD_W-1:0] payload, input bit damage);
        window_t     w;
        int unsigned pos;
        foreach (w[i])
            w[i] = rand_byte();
        for (int k = 0; k < PAYLOAD_BYTES; k++)
            if (PAYLOAD_AT + k < WIN_LEN - 1)
                w[PAYLOAD_AT + k] = payload[PAYLOAD_W-1-BYTE_W*k -: BYTE_W];
        w[ADDR_AT] = addr;
        w[SYNC_AT] = sync;
        w[WIN_LEN-1] = window_crc(w);
        if (damage)
        begin
            pos = $urandom_range(0, WIN_LEN - 1);
            w[pos] = w[pos] ^ (8'h01 << $urandom_range(0, BYTE_W - 1));
        end
        foreach (w[i])
            send_byte(w[i]);
    endtask

    task automatic test_default_registers();
        send_frame(SYNC_RESET, ADDR_RESET, 32'h00FF_A55A, 1'b0);
    endtask

    // all-zero window matches its own crc, so zeros find a frame on every byte
    task automatic test_zero_frames();
        set_config(8'h00, 8'h00);
        repeat (4) send_byte(8'h00);
    endtask

    task automatic test_extreme_registers();
        set_config(8'hFF, 8'hFF);
        send_frame(8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_spare_indexes();
        settle_results();
        write_reg(CFG_SPARE_2, rand_byte());
        write_reg(CFG_SPARE_3, rand_byte());
        send_frame(sync_value, addr_value, $urandom(), 1'b0);
    endtask

    task automatic test_random_traffic(input int unsigned n_bytes, input logic [BYTE_W-1:0] sync,
                                       input logic [BYTE_W-1:0] addr);
        int unsigned sent;
        int unsigned pick;
        int unsigned burst;
        set_config(sync, addr);
        sent = 0;
        while (sent < n_bytes)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                if (pick < 65)
                    send_frame(sync_value, addr_value, $urandom(), 1'b0);
                else if (pick < 78)
                    send_frame(sync_value, addr_value, $urandom(), 1'b1);
                else
                    send_frame(rand_byte(), rand_byte(), $urandom(), 1'b0);
                sent += WIN_LEN;
            end
            else
            begin
                burst = $urandom_range(1, 10);
                repeat (burst) send_byte(rand_byte());
                sent += burst;
            end
            if ($urandom_range(0, 49) == 0)
                settle_results();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_registers();
        test_zero_frames();
        test_extreme_registers();
        test_spare_indexes();
        test_random_traffic(280, rand_byte(), rand_byte());
        test_random_traffic(280, 8'h00, 8'hFF);
        test_random_traffic(280, 8'hFF, 8'h00);
        test_random_traffic(280, SYNC_RESET, ADDR_RESET);
        test_random_traffic(280, rand_byte(), rand_byte());
        settle_results();
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("[crc8_framed_datagram_receiver_top] OK");
        else
            $display("[crc8_framed_datagram_receiver_top] ERROR");
        $finish;
    end

endmodule
